@@ rtl/core/adi_pkg.sv @@
package adi_pkg;

  localparam int AXES      = 6;
  localparam int LIN_AXES  = 3;
  localparam int AXIS_W    = $clog2(AXES);
  localparam int PC_W      = 4;

  localparam int WRENCH_W  = 32;
  localparam int VEL_W     = 18;
  localparam int POS_W     = 32;
  localparam int GAIN_W    = 32;
  localparam int LIM_W     = 17;
  localparam int STEP_W    = 16;
  localparam int GAIN_SHIFT = 24;
  localparam int STEP_SHIFT = 16;

  // shared multiplier: 33-bit signed by 17-bit signed
  localparam int MA_W   = WRENCH_W + 1;
  localparam int MB_W   = GAIN_W / 2 + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = MA_W + GAIN_W;
  localparam int VFULL_W = ACC_W - GAIN_SHIFT;

  localparam int IN_TDATA_W  = AXES * WRENCH_W;
  localparam int OUT_BITS    = AXES * (VEL_W + POS_W);
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [2:0] REG_LIN_GAIN  = 3'd0;
  localparam logic [2:0] REG_ANG_GAIN  = 3'd1;
  localparam logic [2:0] REG_FORCE_OFS = 3'd2;
  localparam logic [2:0] REG_DEADBAND  = 3'd3;
  localparam logic [2:0] REG_VEL_LIMIT = 3'd4;
  localparam logic [2:0] REG_TIME_STEP = 3'd5;

  localparam logic [GAIN_W-1:0]   RST_LIN_GAIN  = 32'd125829;
  localparam logic [GAIN_W-1:0]   RST_ANG_GAIN  = 32'd8388608;
  localparam logic [WRENCH_W-1:0] RST_FORCE_OFS = 32'd1311;
  localparam logic [LIM_W-1:0]    RST_DEADBAND  = 17'd66;
  localparam logic [LIM_W-1:0]    RST_VEL_LIMIT = 17'd13107;
  localparam logic [STEP_W-1:0]   RST_TIME_STEP = 16'd2621;

  typedef struct packed {
    logic [GAIN_W-1:0]   lin_gain;
    logic [GAIN_W-1:0]   ang_gain;
    logic [WRENCH_W-1:0] force_ofs;
    logic [LIM_W-1:0]    deadband;
    logic [LIM_W-1:0]    vel_limit;
    logic [STEP_W-1:0]   time_step;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ADD_HI,
    OP_LIMIT,
    OP_MUL_TS,
    OP_ACCUM,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    op_t             op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_t               op;
    logic [AXIS_W-1:0] axis;
    logic              idle;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_LOAD   = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_LO = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_HI = 4'd3;
  localparam logic [PC_W-1:0] PC_ADD_HI = 4'd4;
  localparam logic [PC_W-1:0] PC_LIMIT  = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_TS = 4'd6;
  localparam logic [PC_W-1:0] PC_ACCUM  = 4'd7;
  localparam logic [PC_W-1:0] PC_DONE   = 4'd8;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_IDLE:   w = '{op: OP_NOP,    jmp: JMP_WAIT_IN,  target: PC_LOAD};
      PC_LOAD:   w = '{op: OP_LOAD,   jmp: JMP_NONE,     target: PC_IDLE};
      PC_MUL_LO: w = '{op: OP_MUL_LO, jmp: JMP_NONE,     target: PC_IDLE};
      PC_MUL_HI: w = '{op: OP_MUL_HI, jmp: JMP_NONE,     target: PC_IDLE};
      PC_ADD_HI: w = '{op: OP_ADD_HI, jmp: JMP_NONE,     target: PC_IDLE};
      PC_LIMIT:  w = '{op: OP_LIMIT,  jmp: JMP_NONE,     target: PC_IDLE};
      PC_MUL_TS: w = '{op: OP_MUL_TS, jmp: JMP_NONE,     target: PC_IDLE};
      PC_ACCUM:  w = '{op: OP_ACCUM,  jmp: JMP_LOOP,     target: PC_LOAD};
      PC_DONE:   w = '{op: OP_DONE,   jmp: JMP_WAIT_OUT, target: PC_IDLE};
      default:   w = '{op: OP_NOP,    jmp: JMP_NONE,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/adi_seq.sv @@
module adi_seq
  import adi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_free,
  output ctrl_t ctrl
);

  logic [PC_W-1:0]   pc, pc_next;
  logic [AXIS_W-1:0] axis, axis_next;
  ucode_t            uw;

  assign uw = ucode_rom(pc);

  always_comb begin
    pc_next   = pc + PC_W'(1);
    axis_next = axis;
    case (uw.jmp)
      JMP_NONE: begin
        pc_next = pc + PC_W'(1);
      end
      JMP_WAIT_IN: begin
        if (start) begin
          pc_next   = uw.target;
          axis_next = '0;
        end else begin
          pc_next = pc;
        end
      end
      JMP_LOOP: begin
        if (axis != AXIS_W'(AXES - 1)) begin
          pc_next   = uw.target;
          axis_next = axis + AXIS_W'(1);
        end
      end
      JMP_WAIT_OUT: begin
        pc_next = out_free ? uw.target : pc;
      end
      default: begin
        pc_next = PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_IDLE;
      axis <= '0;
    end else begin
      pc   <= pc_next;
      axis <= axis_next;
    end
  end

  assign ctrl.op   = uw.op;
  assign ctrl.axis = axis;
  assign ctrl.idle = (uw.jmp == JMP_WAIT_IN);

endmodule

@@ rtl/core/adi_dp.sv @@
module adi_dp
  import adi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  cfg_t                cfg,
  input  logic [WRENCH_W-1:0] wrench [AXES],
  output logic [VEL_W-1:0]    vel    [AXES],
  output logic [POS_W-1:0]    pos    [AXES]
);

  logic signed [MA_W-1:0]    d_reg;
  logic signed [PROD_W-1:0]  prod_reg;
  logic signed [ACC_W-1:0]   acc;
  logic signed [VEL_W-1:0]   v_reg;

  logic                      is_lin;
  logic [GAIN_W-1:0]         gain;
  logic signed [WRENCH_W:0]  w_ext;
  logic signed [MA_W-1:0]    a_op;
  logic signed [MB_W-1:0]    b_op;
  logic signed [PROD_W-1:0]  prod_next;

  logic signed [VFULL_W-1:0] vfull;
  logic [VFULL_W-1:0]        vmag;
  logic signed [VFULL_W-1:0] vdb;
  logic signed [VFULL_W-1:0] lim_pos;
  logic signed [VFULL_W-1:0] vclamp;

  logic signed [PROD_W-STEP_SHIFT-1:0] pstep;
  logic signed [POS_W+1:0]   psum;
  logic [POS_W-1:0]          psat;

  assign is_lin = (ctrl.axis < AXIS_W'(LIN_AXES));
  assign gain   = is_lin ? cfg.lin_gain : cfg.ang_gain;
  assign w_ext  = $signed({wrench[ctrl.axis][WRENCH_W-1], wrench[ctrl.axis]});

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      OP_MUL_LO: begin
        a_op = d_reg;
        b_op = $signed({1'b0, gain[GAIN_W/2-1:0]});
      end
      OP_MUL_HI: begin
        a_op = d_reg;
        b_op = $signed({1'b0, gain[GAIN_W-1:GAIN_W/2]});
      end
      OP_MUL_TS: begin
        a_op = MA_W'(v_reg);
        b_op = $signed({{(MB_W-STEP_W){1'b0}}, cfg.time_step});
      end
      default: begin
        a_op = d_reg;
        b_op = '0;
      end
    endcase
  end

  assign prod_next = a_op * b_op;

  // deadband then clamp
  assign vfull   = acc[ACC_W-1:GAIN_SHIFT];
  assign vmag    = vfull[VFULL_W-1] ? (~vfull + VFULL_W'(1)) : vfull;
  assign vdb     = (vmag < VFULL_W'(cfg.deadband)) ? '0 : vfull;
  assign lim_pos = $signed(VFULL_W'(cfg.vel_limit));

  always_comb begin
    if (vdb > lim_pos) begin
      vclamp = lim_pos;
    end else if (vdb < -lim_pos) begin
      vclamp = -lim_pos;
    end else begin
      vclamp = vdb;
    end
  end

  // saturating position update
  assign pstep = prod_reg[PROD_W-1:STEP_SHIFT];
  assign psum  = (POS_W+2)'($signed(pos[ctrl.axis])) + (POS_W+2)'(pstep);

  always_comb begin
    if (psum > $signed((POS_W+2)'({1'b0, {(POS_W-1){1'b1}}}))) begin
      psat = {1'b0, {(POS_W-1){1'b1}}};
    end else if (psum < -$signed((POS_W+2)'({1'b1, {(POS_W-1){1'b0}}}))) begin
      psat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      psat = psum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        d_reg <= is_lin ? (w_ext - $signed({cfg.force_ofs[WRENCH_W-1], cfg.force_ofs}))
                        : w_ext;
      end
      OP_MUL_LO: begin
        prod_reg <= prod_next;
      end
      OP_MUL_HI: begin
        prod_reg <= prod_next;
        acc      <= ACC_W'(prod_reg);
      end
      OP_ADD_HI: begin
        acc <= acc + (ACC_W'(prod_reg) <<< (GAIN_W / 2));
      end
      OP_LIMIT: begin
        v_reg           <= vclamp[VEL_W-1:0];
        vel[ctrl.axis]  <= vclamp[VEL_W-1:0];
      end
      OP_MUL_TS: begin
        prod_reg <= prod_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        pos[i] <= '0;
      end
    end else if (ctrl.op == OP_ACCUM) begin
      pos[ctrl.axis] <= psat;
    end
  end

endmodule

@@ rtl/core/admittance_damping_integrator.sv @@
// Damping-only admittance stage. Each request on s_* is one wrench (three
// forces, three torques, signed Q16.16); the block returns one result with
// six deadbanded and clamped velocities and six saturating position sums.
// One shared 33x17 multiplier does all the work under a microcoded step
// sequencer that runs these steps per axis: operand load, two gain partial
// products, partial-product add, deadband/clamp, time-step product,
// accumulate. No new wrench is taken until the previous result has been
// written to the output register, which waits while that register is full;
// a new wrench is then taken while that result still waits there. Gains
// and time step are pure scalings; positions reset to zero.
module admittance_damping_integrator
  import adi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // vel_x, vel_y, vel_z, rate_x, rate_y, rate_z,
  // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t                cfg;
  ctrl_t               ctrl;
  logic [WRENCH_W-1:0] wrench [AXES];
  logic [VEL_W-1:0]    vel    [AXES];
  logic [POS_W-1:0]    pos    [AXES];
  logic                start;
  logic                out_free;
  logic                publish;
  logic [OUT_TDATA_W-1:0] result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lin_gain  <= RST_LIN_GAIN;
      cfg.ang_gain  <= RST_ANG_GAIN;
      cfg.force_ofs <= RST_FORCE_OFS;
      cfg.deadband  <= RST_DEADBAND;
      cfg.vel_limit <= RST_VEL_LIMIT;
      cfg.time_step <= RST_TIME_STEP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LIN_GAIN:  cfg.lin_gain  <= cfg_data;
        REG_ANG_GAIN:  cfg.ang_gain  <= cfg_data;
        REG_FORCE_OFS: cfg.force_ofs <= cfg_data;
        REG_DEADBAND:  cfg.deadband  <= cfg_data[LIM_W-1:0];
        REG_VEL_LIMIT: cfg.vel_limit <= cfg_data[LIM_W-1:0];
        REG_TIME_STEP: cfg.time_step <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = ctrl.idle;
  assign start    = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign publish  = (ctrl.op == OP_DONE) & out_free;

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < AXES; i++) begin
        wrench[i] <= s_tdata[i*WRENCH_W +: WRENCH_W];
      end
    end
  end

  adi_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  adi_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .wrench (wrench),
    .vel    (vel),
    .pos    (pos)
  );

  always_comb begin
    result = '0;
    for (int i = 0; i < AXES; i++) begin
      result[i*VEL_W +: VEL_W]                = vel[i];
      result[AXES*VEL_W + i*POS_W +: POS_W]   = pos[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      m_tdata <= result;
    end
  end

endmodule

@@ bench/adi_checker.sv @@
`timescale 1ns / 1ps

module adi_checker
  import adi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     errors,
  output int                     pending
);

  localparam int PRINT_CAP = 50;

  cfg_t                     tuning;
  logic signed [POS_W-1:0]  axis_pos [AXES];
  logic [OUT_TDATA_W-1:0]   expected_motion [$];

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) begin
      $display("adi_checker: %s", msg);
    end
    errors++;
  endtask

  // Damping, deadband, clamp and saturating integration for all six axes.
  task automatic integrate_wrench(input logic [IN_TDATA_W-1:0] wrench,
                                  output logic [OUT_TDATA_W-1:0] motion);
    logic signed [WRENCH_W:0]          diff;
    logic signed [GAIN_W:0]            gain;
    logic signed [WRENCH_W+GAIN_W+1:0] prod;
    logic signed [WRENCH_W+GAIN_W+1:0] scaled;
    longint vel, mag, db, lim, ts, step, sum;
    motion = '0;
    db  = tuning.deadband;
    lim = tuning.vel_limit;
    ts  = tuning.time_step;
    for (int a = 0; a < AXES; a++) begin
      diff = $signed(wrench[a*WRENCH_W +: WRENCH_W]);
      if (a < LIN_AXES) begin
        diff = diff - $signed(tuning.force_ofs);
        gain = {1'b0, tuning.lin_gain};
      end else begin
        gain = {1'b0, tuning.ang_gain};
      end
      // 33 x 33 signed product is exact in 66 bits; >>> floors
      prod   = diff * gain;
      scaled = prod >>> GAIN_SHIFT;
      vel    = scaled[63:0];
      mag    = (vel < 0) ? -vel : vel;
      if (mag < db) vel = 0;
      // clamp is applied after the deadband and not retested
      if (vel > lim) vel = lim;
      else if (vel < -lim) vel = -lim;
      step = (vel * ts) >>> STEP_SHIFT;
      sum  = axis_pos[a];
      sum  = sum + step;
      if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
      else if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
      axis_pos[a] = sum[POS_W-1:0];
      motion[a*VEL_W +: VEL_W]                 = vel[VEL_W-1:0];
      motion[AXES*VEL_W + a*POS_W +: POS_W]    = sum[POS_W-1:0];
    end
  endtask

  task automatic compare_motion(input logic [OUT_TDATA_W-1:0] want_bits);
    longint got, want;
    string  kind;
    for (int f = 0; f < 2*AXES; f++) begin
      if (f < AXES) begin
        kind = "velocity";
        got  = $signed(m_tdata[f*VEL_W +: VEL_W]);
        want = $signed(want_bits[f*VEL_W +: VEL_W]);
      end else begin
        kind = "position";
        got  = $signed(m_tdata[AXES*VEL_W + (f-AXES)*POS_W +: POS_W]);
        want = $signed(want_bits[AXES*VEL_W + (f-AXES)*POS_W +: POS_W]);
      end
      if (got != want) begin
        report_mismatch($sformatf("%s axis %0d: got %0d, expected %0d",
                                  kind, f % AXES, got, want));
      end
    end
    if (m_tdata[OUT_TDATA_W-1:OUT_BITS] != '0) begin
      report_mismatch("nonzero fill bits in result");
    end
  endtask

  // Sample at the falling edge: inputs and registered outputs are settled
  // and the handshake seen here completes at the next rising edge.
  always @(negedge clk) begin
    logic [OUT_TDATA_W-1:0] motion;
    if (rst) begin
      tuning.lin_gain  = RST_LIN_GAIN;
      tuning.ang_gain  = RST_ANG_GAIN;
      tuning.force_ofs = RST_FORCE_OFS;
      tuning.deadband  = RST_DEADBAND;
      tuning.vel_limit = RST_VEL_LIMIT;
      tuning.time_step = RST_TIME_STEP;
      for (int a = 0; a < AXES; a++) axis_pos[a] = '0;
      expected_motion.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIN_GAIN:  tuning.lin_gain  = cfg_data;
          REG_ANG_GAIN:  tuning.ang_gain  = cfg_data;
          REG_FORCE_OFS: tuning.force_ofs = cfg_data;
          REG_DEADBAND:  tuning.deadband  = cfg_data[LIM_W-1:0];
          REG_VEL_LIMIT: tuning.vel_limit = cfg_data[LIM_W-1:0];
          REG_TIME_STEP: tuning.time_step = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        integrate_wrench(s_tdata, motion);
        expected_motion.push_back(motion);
      end
      if (m_tvalid && m_tready) begin
        if (expected_motion.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          motion = expected_motion.pop_front();
          compare_motion(motion);
        end
      end
    end
    pending = expected_motion.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import adi_pkg::*;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int SOAK_ITEMS   = 60;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 110;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  int chk_errors;
  int chk_pending;
  int quiet_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int ofs_now = RST_FORCE_OFS;

  admittance_damping_integrator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  adi_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(chk_errors), .pending(chk_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stall before each result while rx_idle is set
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      @(posedge clk);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_wrench(
      input logic [31:0] fx, fy, fz, tx, ty, tz);
    return {tz, ty, tx, fz, fy, fx};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_wrench();
    logic [IN_TDATA_W-1:0] d;
    int f;
    for (int a = 0; a < AXES; a++) begin
      f = $urandom;
      case ($urandom_range(0, 3))
        0: ;
        1, 2: f = f >>> $urandom_range(8, 30);
        default: begin
          // forces near the bias exercise the deadband
          if (a < LIN_AXES) f = ofs_now + (f >>> $urandom_range(16, 30));
          else f = f >>> $urandom_range(20, 31);
        end
      endcase
      d[a*WRENCH_W +: WRENCH_W] = f;
    end
    return d;
  endfunction

  task automatic send_wrench(input logic [IN_TDATA_W-1:0] wrench);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= wrench;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // all six registers plus one unmapped index, which must be ignored
  task automatic load_tuning(input logic [31:0] lin, ang, ofs, db, lim, ts);
    write_reg(REG_LIN_GAIN, lin);
    write_reg(REG_ANG_GAIN, ang);
    write_reg(REG_FORCE_OFS, ofs);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_VEL_LIMIT, lim);
    write_reg(REG_TIME_STEP, ts);
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
    ofs_now = ofs;
  endtask

  task automatic wait_idle();
    while (chk_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] lin, ang, db, lim, ts;
    int ofs;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset tuning: zero, rails, force equal to bias, tiny negative torque, mixed rails, random
    send_wrench('0);
    send_wrench({AXES{32'h7FFF_FFFF}});
    send_wrench({AXES{32'h8000_0000}});
    send_wrench(pack_wrench(RST_FORCE_OFS, RST_FORCE_OFS, RST_FORCE_OFS,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_wrench(pack_wrench(32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'd1));
    send_wrench(random_wrench());
    s_tvalid <= 1'b0;

    // max gains, most negative bias: 33-bit force difference at the top
    wait_idle();
    load_tuning(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0,
                32'h1_FFFF, 32'hFFFF);
    send_wrench({AXES{32'h7FFF_FFFF}});
    send_wrench({AXES{32'h8000_0000}});
    send_wrench(pack_wrench(32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'd0, 32'h8000_0000, 32'h7FFF_FFFF));
    s_tvalid <= 1'b0;

    // deadband above limit; most positive bias gives the widest negative diff
    wait_idle();
    load_tuning(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd100000,
                32'd50000, 32'd40000);
    send_wrench(pack_wrench(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'd273, 32'd500, -32'sd500));
    send_wrench(pack_wrench(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            -32'sd273, -32'sd390, 32'd391));
    s_tvalid <= 1'b0;

    // everything zero
    wait_idle();
    load_tuning(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_wrench(random_wrench());
    send_wrench({AXES{32'h8000_0000}});
    s_tvalid <= 1'b0;

    // back to back at full step: linear positions climb, angles fall
    wait_idle();
    load_tuning(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h1_FFFF, 32'hFFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (SOAK_ITEMS) begin
      send_wrench(pack_wrench(($urandom & 32'h3FFF_FFFF) | 32'h4000_0000,
                              ($urandom & 32'h3FFF_FFFF) | 32'h4000_0000,
                              ($urandom & 32'h3FFF_FFFF) | 32'h4000_0000,
                              ($urandom & 32'h3FFF_FFFF) | 32'h8000_0000,
                              ($urandom & 32'h3FFF_FFFF) | 32'h8000_0000,
                              ($urandom & 32'h3FFF_FFFF) | 32'h8000_0000));
    end
    s_tvalid <= 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      lin = $urandom >> $urandom_range(0, 24);
      ang = $urandom >> $urandom_range(0, 24);
      ofs = $urandom;
      ofs = ofs >>> $urandom_range(0, 31);
      db  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000);
      lim = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 131071);
      ts  = $urandom;
      load_tuning(lin, ang, ofs, db, lim, ts);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      repeat (PHASE_ITEMS) send_wrench(random_wrench());
      s_tvalid <= 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/adi_pkg.sv
rtl/core/adi_seq.sv
rtl/core/adi_dp.sv
rtl/core/admittance_damping_integrator.sv
bench/adi_checker.sv
bench/tb_top.sv
